// File: rtl/mris_pkg.sv
package mris_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DIMS_DEF   = 4;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths
  localparam int SIZE_REGS  = 4;
  localparam int SIZE_BITS  = 16;
  localparam int STEP_BITS  = 16;
  localparam int DIMS_BITS  = 3;
  localparam int OUT_COORDS = 4;
  localparam int OUT_BITS   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_3  = 3'd4;

  // Operation codes
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Completion status that one cell reports to the controller
  typedef struct packed {
    logic stop;       // carry absorbed in this cell
    logic carry_vld;  // quotient ready for the next outer cell
  } cell_stat_t;

endpackage

// File: rtl/mris_cell.sv
module mris_cell import mris_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SUM_W      = 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SIZE_BITS-1:0]  size,
  input  logic                  zero_en,
  input  logic                  tok_vld,
  input  logic [SUM_W-1:0]      tok_carry,
  output logic [COORD_BITS-1:0] coord,
  output logic [SUM_W-1:0]      carry_out,
  output cell_stat_t            stat
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [COORD_BITS-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0]      quo_r, quo_nxt;
  logic [SIZE_BITS-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  stop_r, stop_nxt;
  logic                  cvld_r, cvld_nxt;

  logic [SUM_W-1:0]      sum;
  logic                  fits;
  logic [SIZE_BITS:0]    trial;
  logic                  ge;
  logic [SIZE_BITS-1:0]  rem_step;

  assign sum      = SUM_W'(pos_r) + tok_carry;
  assign fits     = sum < SUM_W'(size);
  // restoring division: one quotient bit per cycle
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign ge       = trial >= {1'b0, size};
  assign rem_step = ge ? SIZE_BITS'(trial - {1'b0, size}) : SIZE_BITS'(trial);

  always_comb begin
    pos_nxt  = pos_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    stop_nxt = 1'b0;
    cvld_nxt = 1'b0;
    if (zero_en) begin
      pos_nxt = '0;
    end
    if (tok_vld) begin
      if (fits) begin
        pos_nxt  = COORD_BITS'(sum);
        stop_nxt = 1'b1;
      end else begin
        quo_nxt  = sum;
        rem_nxt  = '0;
        cnt_nxt  = CNT_W'(SUM_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      rem_nxt = rem_step;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        cvld_nxt = 1'b1;
        pos_nxt  = COORD_BITS'(rem_step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      busy_r <= 1'b0;
      stop_r <= 1'b0;
      cvld_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      busy_r <= busy_nxt;
      stop_r <= stop_nxt;
      cvld_r <= cvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign coord          = pos_r;
  assign carry_out      = quo_r;
  assign stat.stop      = stop_r;
  assign stat.carry_vld = cvld_r;

endmodule

// File: rtl/mixed_radix_index_stepper.sv
// Mixed-radix index stepper: holds a position in an array of up to MAX_DIMS
// dimensions (dimension zero outermost) and steps it one word at a time.
// Input channel (in_valid/in_stall): a word either clears the whole position
// (in_op = clear) or adds in_step at a starting dimension and carries outward.
// Result channel (out_valid/out_stall): one word per input word with all
// coordinates after the step and out_wrapped when a carry left dimension zero.
// Configuration (cfg_wr_en/cfg_index/cfg_data): dims_in_use and four dimension
// sizes; write only while no word is in flight.
// Throughput: one word at a time. A clear goes straight to the done state; an
// advance runs the cell chain, and every dimension whose sum overflows its size
// divides in its bit-serial divider (SUM_W quotient bits, SUM_W = 19 with
// default parameters) before it hands its carry to the next outer dimension.
// Reset: all coordinates zero, dims_in_use = 4, every size 1, no result pending.
// A stalled result word holds in the output register; the block still takes
// the next word, but its finished step waits until the held word has left.
module mixed_radix_index_stepper import mris_pkg::*; #(
  parameter int MAX_DIMS   = MAX_DIMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [STEP_BITS-1:0]  in_step,
  input  logic                  in_from_last,
  input  logic [1:0]            in_start_dim,
  input  logic                  in_clear_lower,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_BITS-1:0]   out_coord_0,
  output logic [OUT_BITS-1:0]   out_coord_1,
  output logic [OUT_BITS-1:0]   out_coord_2,
  output logic [OUT_BITS-1:0]   out_coord_3,
  output logic                  out_wrapped
);

  // Carry width: a carry gathers at most one coordinate per dimension on top
  // of the step, so this never overflows.
  localparam int WIDE_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  localparam int SUM_W     = WIDE_BITS + $clog2(MAX_DIMS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Configuration registers
  logic [DIMS_BITS-1:0] dims_in_use_r;
  logic [SIZE_BITS-1:0] dim_size_r [SIZE_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_in_use_r <= DIMS_BITS'(4);
      for (int i = 0; i < SIZE_REGS; i++) begin
        dim_size_r[i] <= SIZE_BITS'(1);
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DIMS_IN_USE: dims_in_use_r <= cfg_data[DIMS_BITS-1:0];
        CFG_DIM_SIZE_0:  dim_size_r[0] <= cfg_data[SIZE_BITS-1:0];
        CFG_DIM_SIZE_1:  dim_size_r[1] <= cfg_data[SIZE_BITS-1:0];
        CFG_DIM_SIZE_2:  dim_size_r[2] <= cfg_data[SIZE_BITS-1:0];
        CFG_DIM_SIZE_3:  dim_size_r[3] <= cfg_data[SIZE_BITS-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Dimensions in use: zero counts as one, saturate at MAX_DIMS
  logic [3:0] dims_raw, used, last_dim, start;
  logic       in_acc;

  assign dims_raw = {1'b0, dims_in_use_r};
  assign used     = (dims_raw == 4'd0)            ? 4'd1 :
                    (dims_raw > 4'(MAX_DIMS))     ? 4'(MAX_DIMS) : dims_raw;
  assign last_dim = used - 4'd1;
  assign start    = in_from_last                    ? last_dim :
                    ({2'b00, in_start_dim} >= used) ? last_dim : {2'b00, in_start_dim};
  assign in_acc   = in_valid && !in_stall;

  // Cell chain: the carry walks from the starting cell toward cell zero
  cell_stat_t            stat      [MAX_DIMS];
  logic [SUM_W-1:0]      carry_out [MAX_DIMS];
  logic [COORD_BITS-1:0] cell_coord[MAX_DIMS];
  logic [MAX_DIMS-1:0]   stop_vec;

  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_cell
    logic [SIZE_BITS-1:0] size;
    logic                 zero_en;
    logic                 inj;
    logic                 tok_vld;
    logic [SUM_W-1:0]     tok_carry;

    if (j < SIZE_REGS) begin : g_size
      assign size = (dim_size_r[j] == '0) ? SIZE_BITS'(1) : dim_size_r[j];
    end else begin : g_size_one
      assign size = SIZE_BITS'(1);
    end

    // zero on clear, when out of use, or below the start with clear_lower
    assign zero_en = in_acc && (in_op == OP_CLEAR || 4'(j) >= used ||
                                (in_clear_lower && 4'(j) > start));
    assign inj     = in_acc && in_op == OP_ADVANCE && start == 4'(j);

    if (j == MAX_DIMS - 1) begin : g_top
      assign tok_vld   = inj;
      assign tok_carry = SUM_W'(in_step);
    end else begin : g_link
      assign tok_vld   = inj || stat[j+1].carry_vld;
      assign tok_carry = inj ? SUM_W'(in_step) : carry_out[j+1];
    end

    mris_cell #(
      .COORD_BITS (COORD_BITS),
      .SUM_W      (SUM_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .size      (size),
      .zero_en   (zero_en),
      .tok_vld   (tok_vld),
      .tok_carry (tok_carry),
      .coord     (cell_coord[j]),
      .carry_out (carry_out[j]),
      .stat      (stat[j])
    );

    assign stop_vec[j] = stat[j].stop;
  end

  // Control: the step ends when a cell absorbs the carry or cell zero overflows
  logic [1:0] state_r, state_nxt;
  logic       wrap_r, wrap_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       stop_any, wrap_ev, load;

  assign stop_any = |stop_vec;
  assign wrap_ev  = stat[0].carry_vld;
  assign load     = state_r == ST_DONE && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    wrap_nxt  = wrap_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          wrap_nxt  = 1'b0;
          state_nxt = (in_op == OP_CLEAR) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (stop_any || wrap_ev) begin
          wrap_nxt  = wrap_ev;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wrap_r      <= wrap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register: capture the coordinates once the chain has settled
  logic [OUT_BITS-1:0] coord_ext  [OUT_COORDS];
  logic [OUT_BITS-1:0] out_coord_r[OUT_COORDS];
  logic                out_wrap_r;

  for (genvar k = 0; k < OUT_COORDS; k++) begin : g_out
    if (k < MAX_DIMS) begin : g_used
      assign coord_ext[k] = OUT_BITS'(cell_coord[k]);
    end else begin : g_none
      assign coord_ext[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < OUT_COORDS; k++) begin
        out_coord_r[k] <= coord_ext[k];
      end
      out_wrap_r <= wrap_r;
    end
  end

  assign in_stall    = state_r != ST_IDLE;
  assign out_valid   = out_valid_r;
  assign out_coord_0 = out_coord_r[0];
  assign out_coord_1 = out_coord_r[1];
  assign out_coord_2 = out_coord_r[2];
  assign out_coord_3 = out_coord_r[3];
  assign out_wrapped = out_wrap_r;

`ifndef NO_ASSERTIONS
  // only one cell may finish a step in any cycle
  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({stop_vec, wrap_ev}))
    else $error("more than one cell finished in the same cycle");

  // cells report completion only while a step is running
  a_event_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (stop_any || wrap_ev) |-> state_r == ST_RUN)
    else $error("cell completion outside a running step");

  // a new result word comes only out of the done state
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result word raised without a finished step");
`endif

endmodule

// File: test/mixed_radix_index_checker.sv
module mixed_radix_index_checker import mris_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_op,
  input  logic [STEP_BITS-1:0]  in_step,
  input  logic                  in_from_last,
  input  logic [1:0]            in_start_dim,
  input  logic                  in_clear_lower,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [OUT_BITS-1:0]   out_coord_0,
  input  logic [OUT_BITS-1:0]   out_coord_1,
  input  logic [OUT_BITS-1:0]   out_coord_2,
  input  logic [OUT_BITS-1:0]   out_coord_3,
  input  logic                  out_wrapped,
  output int                    mismatch_count,
  output int                    words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_COORDS-1:0][OUT_BITS-1:0] coord;
    logic                                wrapped;
  } coord_word_t;

  logic [DIMS_BITS-1:0] dims_shadow;
  logic [SIZE_BITS-1:0] size_shadow [SIZE_REGS];
  logic [OUT_BITS-1:0]  position [MAX_DIMS_DEF];
  coord_word_t          expected_coords_q [$];

  task automatic report_mismatch(input string msg);
    // cap the log, keep counting
    if (mismatch_count < 40)
      $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  // Update the shadow position for one accepted word and return its coordinates.
  function automatic coord_word_t step_position(input logic op,
                                                input logic [STEP_BITS-1:0] step,
                                                input logic from_last,
                                                input logic [1:0] start_dim,
                                                input logic clear_lower);
    int          used;
    int          first;
    logic [31:0] carry;
    logic [31:0] sum;
    logic [31:0] radix;
    bit          stopped;
    coord_word_t res;
    used = (dims_shadow == 0) ? 1 :
           (dims_shadow > MAX_DIMS_DEF) ? MAX_DIMS_DEF : int'(dims_shadow);
    res.wrapped = 1'b0;
    if (op == OP_CLEAR) begin
      for (int k = 0; k < MAX_DIMS_DEF; k++)
        position[k] = '0;
    end else begin
      first = from_last ? used - 1 : ((int'(start_dim) >= used) ? used - 1 : int'(start_dim));
      carry = 32'(step);
      stopped = 1'b0;
      for (int k = first; k >= 0; k--) begin
        if (!stopped) begin
          radix = (size_shadow[k] == 0) ? 32'd1 : 32'(size_shadow[k]);
          sum = 32'(position[k]) + carry;
          if (sum < radix) begin
            position[k] = sum[OUT_BITS-1:0];
            stopped = 1'b1;
          end else begin
            carry = sum / radix;
            position[k] = OUT_BITS'(sum % radix);
            if (k == 0)
              res.wrapped = 1'b1;
          end
        end
      end
      if (clear_lower) begin
        for (int k = first + 1; k < used; k++)
          position[k] = '0;
      end
    end
    for (int k = used; k < MAX_DIMS_DEF; k++)
      position[k] = '0;
    for (int k = 0; k < OUT_COORDS; k++)
      res.coord[k] = (k < MAX_DIMS_DEF) ? position[k] : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    coord_word_t got;
    coord_word_t want;
    if (!rst_n) begin
      dims_shadow = DIMS_BITS'(4);
      for (int k = 0; k < SIZE_REGS; k++)
        size_shadow[k] = SIZE_BITS'(1);
      for (int k = 0; k < MAX_DIMS_DEF; k++)
        position[k] = '0;
      expected_coords_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DIMS_IN_USE: dims_shadow = cfg_data[DIMS_BITS-1:0];
          CFG_DIM_SIZE_0, CFG_DIM_SIZE_1, CFG_DIM_SIZE_2, CFG_DIM_SIZE_3: begin
            size_shadow[2'(cfg_index - CFG_DIM_SIZE_0)] = cfg_data[SIZE_BITS-1:0];
          end
          default: ;
        endcase
      end
      // retire the oldest expectation before adding a new one
      if (out_valid && !out_stall) begin
        got.coord = {out_coord_3, out_coord_2, out_coord_1, out_coord_0};
        got.wrapped = out_wrapped;
        if (expected_coords_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_coords_q[0];
          expected_coords_q.delete(0);
          for (int k = 0; k < OUT_COORDS; k++) begin
            if (got.coord[k] !== want.coord[k])
              report_mismatch($sformatf("coord_%0d: got %0d, expected %0d",
                                        k, got.coord[k], want.coord[k]));
          end
          if (got.wrapped !== want.wrapped)
            report_mismatch($sformatf("wrapped: got %b, expected %b",
                                      got.wrapped, want.wrapped));
        end
      end
      if (in_valid && !in_stall)
        expected_coords_q.push_back(step_position(in_op, in_step, in_from_last,
                                                  in_start_dim, in_clear_lower));
    end
    words_in_flight = expected_coords_q.size();
  end

endmodule

// File: test/mixed_radix_index_stepper_tb.sv
module mixed_radix_index_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mris_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [STEP_BITS-1:0]  in_step;
  logic                  in_from_last;
  logic [1:0]            in_start_dim;
  logic                  in_clear_lower;
  logic                  out_valid;
  logic                  out_stall;
  logic [OUT_BITS-1:0]   out_coord_0;
  logic [OUT_BITS-1:0]   out_coord_1;
  logic [OUT_BITS-1:0]   out_coord_2;
  logic [OUT_BITS-1:0]   out_coord_3;
  logic                  out_wrapped;

  int mismatch_count;
  int words_in_flight;

  // Per-cycle odds (percent) of the sender holding back and the receiver stalling.
  int send_gap_pct;
  int stall_pct;

  mixed_radix_index_stepper dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_step       (in_step),
    .in_from_last  (in_from_last),
    .in_start_dim  (in_start_dim),
    .in_clear_lower(in_clear_lower),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_coord_0   (out_coord_0),
    .out_coord_1   (out_coord_1),
    .out_coord_2   (out_coord_2),
    .out_coord_3   (out_coord_3),
    .out_wrapped   (out_wrapped)
  );

  // Watch both channels and the register port; predict and compare there.
  mixed_radix_index_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_step        (in_step),
    .in_from_last   (in_from_last),
    .in_start_dim   (in_start_dim),
    .in_clear_lower (in_clear_lower),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coord_0    (out_coord_0),
    .out_coord_1    (out_coord_1),
    .out_coord_2    (out_coord_2),
    .out_coord_3    (out_coord_3),
    .out_wrapped    (out_wrapped),
    .mismatch_count (mismatch_count),
    .words_in_flight(words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: draw a fresh stall decision every cycle.
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Hard stop well beyond the slowest legal run (worst carries plus idling).
  initial begin
    #12_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Offer one word and hold it until the block takes it. Leave valid high on
  // return so a back-to-back word needs no second assignment in the same step.
  task automatic send_word(input logic op, input logic [STEP_BITS-1:0] step,
                           input logic from_last, input logic [1:0] start_dim,
                           input logic clear_lower);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct)
        @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_step        <= step;
    in_from_last   <= from_last;
    in_start_dim   <= start_dim;
    in_clear_lower <= clear_lower;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic advance(input logic [STEP_BITS-1:0] step, input logic from_last,
                         input logic [1:0] start_dim, input logic clear_lower);
    send_word(OP_ADVANCE, step, from_last, start_dim, clear_lower);
  endtask

  // Clear ignores every other field: fill them with noise.
  task automatic clear_position();
    send_word(OP_CLEAR, STEP_BITS'($urandom_range(65535)), 1'($urandom_range(1)),
              2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // Drop valid and wait for every outstanding word to come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (words_in_flight == 0);
    @(posedge clk);
  endtask

  // Write all five registers back to back; only called with the block drained.
  task automatic load_shape(input logic [CFG_DATA_W-1:0] dims,
                            input logic [SIZE_BITS-1:0] s0, input logic [SIZE_BITS-1:0] s1,
                            input logic [SIZE_BITS-1:0] s2, input logic [SIZE_BITS-1:0] s3);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DIMS_IN_USE; cfg_data <= dims; @(posedge clk);
    cfg_index <= CFG_DIM_SIZE_0;  cfg_data <= s0;   @(posedge clk);
    cfg_index <= CFG_DIM_SIZE_1;  cfg_data <= s1;   @(posedge clk);
    cfg_index <= CFG_DIM_SIZE_2;  cfg_data <= s2;   @(posedge clk);
    cfg_index <= CFG_DIM_SIZE_3;  cfg_data <= s3;   @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] dims;
    logic [SIZE_BITS-1:0]  sizes [SIZE_REGS];
    logic [STEP_BITS-1:0]  step;
    int                    r;

    // Drive every input to a known value before the first edge.
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_DIMS_IN_USE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_op          = OP_ADVANCE;
    in_step        = '0;
    in_from_last   = 1'b0;
    in_start_dim   = '0;
    in_clear_lower = 1'b0;
    out_stall      = 1'b0;
    send_gap_pct   = 0;
    stall_pct      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset shape is four dims of size one, so any nonzero step
    // carries through every dimension and wraps.
    advance(16'd0, 1'b0, 2'd0, 1'b0);
    advance(16'd1, 1'b1, 2'd0, 1'b0);
    drain();

    // Mixed sizes: largest step from the last dim, carries across one dim, clear
    // of the lower dims, a wrap out of dim zero, full clear.
    load_shape(16'd4, 16'd3, 16'd5, 16'hFFFF, 16'd7);
    advance(16'hFFFF, 1'b1, 2'd0, 1'b0);
    advance(16'hFFFF, 1'b0, 2'd2, 1'b0);
    advance(16'd4, 1'b0, 2'd1, 1'b1);
    advance(16'hFFFF, 1'b0, 2'd0, 1'b0);
    advance(16'd2, 1'b0, 2'd3, 1'b1);
    clear_position();
    advance(16'd6, 1'b0, 2'd3, 1'b0);
    advance(16'd0, 1'b0, 2'd1, 1'b0);
    drain();

    // Two dims in use: a start past the last dim saturates, unused dims read
    // back as zero, from_last overrides start_dim.
    load_shape(16'd2, 16'd2, 16'hFFFF, 16'd9, 16'd9);
    advance(16'd100, 1'b0, 2'd3, 1'b0);
    advance(16'hFFFF, 1'b1, 2'd2, 1'b1);
    drain();

    // Shrink dim one under a coordinate already held there: a zero step
    // must still fold the stale value.
    load_shape(16'd2, 16'd2, 16'd3, 16'd9, 16'd9);
    advance(16'd0, 1'b0, 2'd1, 1'b0);
    drain();

    // Zero dims in use and zero sizes both act as one.
    load_shape(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    advance(16'd5, 1'b0, 2'd2, 1'b1);
    advance(16'd0, 1'b0, 2'd0, 1'b0);
    drain();

    // Dims in use above the maximum saturates; every size at its top.
    load_shape(16'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    advance(16'hFFFF, 1'b1, 2'd0, 1'b0);
    advance(16'hFFFF, 1'b0, 2'd3, 1'b1);
    advance(16'hFFFF, 1'b0, 2'd0, 1'b0);
    clear_position();
    drain();

    // Random phases: a new shape each phase, idling pattern rotating through
    // none, sender only, receiver only and both. Positions carry over from
    // phase to phase, so a shrunken size leaves stale coordinates behind.
    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 45; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 45; end
        default: begin send_gap_pct = 14; stall_pct = 14; end
      endcase

      if (phase == 0) begin
        dims = 16'd4;
        for (int k = 0; k < SIZE_REGS; k++) sizes[k] = 16'hFFFF;
      end else if (phase == 1) begin
        dims = 16'd1;
        for (int k = 0; k < SIZE_REGS; k++) sizes[k] = 16'd1;
      end else begin
        r = $urandom_range(9);
        dims = (r < 8) ? CFG_DATA_W'(1 + r % 4) : CFG_DATA_W'($urandom_range(7));
        // Mostly small radices so carries run deep; some extremes and noise.
        for (int k = 0; k < SIZE_REGS; k++) begin
          r = $urandom_range(9);
          if (r == 0)      sizes[k] = SIZE_BITS'($urandom_range(1));
          else if (r == 1) sizes[k] = 16'hFFFF;
          else if (r < 4)  sizes[k] = SIZE_BITS'($urandom_range(65535));
          else             sizes[k] = SIZE_BITS'($urandom_range(12, 2));
        end
      end
      load_shape(dims, sizes[0], sizes[1], sizes[2], sizes[3]);

      for (int n = 0; n < 103; n++) begin
        if ($urandom_range(99) < 6) begin
          clear_position();
        end else begin
          r = $urandom_range(9);
          if (r < 4)      step = STEP_BITS'($urandom_range(3));
          else if (r < 7) step = STEP_BITS'($urandom_range(255));
          else if (r < 9) step = STEP_BITS'($urandom_range(65535));
          else            step = 16'hFFFF;
          advance(step, 1'($urandom_range(1)), 2'($urandom_range(3)),
                  1'($urandom_range(9) < 3));
        end
      end
      drain();
    end

    // Let any stray late word show up before the verdict.
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
